FILE: rtl/csvf_pkg.sv
// Package for the CSV field prefix match counter.
// Holds sizes, register index codes and the structs shared by the modules.
// No dependencies.
package csvf_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int COUNT_WIDTH       = 32;
  localparam int FIFO_DEPTH        = 2;

  localparam int POS_W       = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W       = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int FIELD_W     = 6;
  localparam int PAT_WORD_W  = 63;
  localparam int PLEN_W      = 5;
  localparam int BYTE_W      = 8;
  localparam int RESULT_W    = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 63;

  localparam logic [FIELD_W-1:0] FIELD_INDEX_MAX = '1;
  localparam logic [BYTE_W-1:0]  FS_RESET        = 8'd44;
  localparam logic [BYTE_W-1:0]  RS_RESET        = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_FIELD     = 3'd0,
    CFG_PATTERN_LOW      = 3'd1,
    CFG_PATTERN_HIGH     = 3'd2,
    CFG_PATTERN_LENGTH   = 3'd3,
    CFG_FIELD_SEPARATOR  = 3'd4,
    CFG_RECORD_SEPARATOR = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [FIELD_W-1:0]    target_field;
    logic [PAT_WORD_W-1:0] pattern_low;
    logic [PAT_WORD_W-1:0] pattern_high;
    logic [PLEN_W-1:0]     pattern_length;
    logic [BYTE_W-1:0]     field_separator;
    logic [BYTE_W-1:0]     record_separator;
  } cfg_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic                         is_rs;
    logic                         is_fs;
    logic [MAX_PATTERN_BYTES-1:0] eq_vec;
    logic                         last;
  } entry_t;

endpackage

FILE: rtl/csvf_in_if.sv
// Input channel of the CSV field prefix match counter: one text byte per transaction.
// Depends on csvf_pkg.
interface csvf_in_if
  import csvf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

FILE: rtl/csvf_out_if.sv
// Result channel of the CSV field prefix match counter: one count per buffer.
// Depends on csvf_pkg.
interface csvf_out_if
  import csvf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] match_count;
  logic                count_saturated;

  modport source (output valid, output match_count, output count_saturated, input ready);
  modport sink   (input valid, input match_count, input count_saturated, output ready);
endinterface

FILE: rtl/csvf_front.sv
// Front part: accepts text bytes and classifies them against separators and pattern.
// Depends on csvf_pkg and csvf_in_if.
module csvf_front
  import csvf_pkg::*;
(
  csvf_in_if.sink  in_bus,
  input  cfg_t     cfg,
  input  logic     fifo_full,
  output logic     push,
  output entry_t   entry
);

  logic [16*BYTE_W-1:0] pat_flat;

  // Top bit of each pattern word is not stored and reads as zero.
  assign pat_flat = {1'b0, cfg.pattern_high, 1'b0, cfg.pattern_low};

  assign in_bus.ready = !fifo_full;
  assign push         = in_bus.valid && !fifo_full;

  always_comb begin
    entry.is_rs = (in_bus.data_byte == cfg.record_separator);
    entry.is_fs = !entry.is_rs && (in_bus.data_byte == cfg.field_separator);
    entry.last  = in_bus.end_of_buffer;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      entry.eq_vec[i] = (pat_flat[i*BYTE_W +: BYTE_W] == in_bus.data_byte);
    end
  end

endmodule

FILE: rtl/csvf_fifo.sv
// Short queue of classified bytes between front and back.
// Depends on csvf_pkg.
module csvf_fifo
  import csvf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output entry_t dout,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  entry_t           slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/csvf_back.sv
// Back part: walks records, decides the target field prefix and keeps the count.
// Holds the result register. Depends on csvf_pkg and csvf_out_if.
module csvf_back
  import csvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  csvf_out_if.source  out_bus
);

  logic [FIELD_W-1:0]     field_index_r,   field_index_nxt;
  logic [POS_W-1:0]       byte_in_field_r, byte_in_field_nxt;
  logic                   prefix_alive_r,  prefix_alive_nxt;
  logic                   record_decided_r, record_decided_nxt;
  logic                   record_matched_r, record_matched_nxt;
  logic [COUNT_WIDTH-1:0] count_r,         count_nxt;
  logic                   sat_r,           sat_nxt;
  logic                   out_valid_r,     out_valid_nxt;
  logic [RESULT_W-1:0]    out_count_r;
  logic                   out_sat_r;

  logic [POS_W-1:0]       used_len;
  logic                   fire;
  logic                   full_pre, full_post, close_now, close_matched;
  logic [FIELD_W-1:0]     fi;
  logic [POS_W-1:0]       bif;
  logic                   alive, dec, mat;

  assign used_len = (cfg.pattern_length > PLEN_W'(MAX_PATTERN_BYTES))
                    ? POS_W'(MAX_PATTERN_BYTES) : POS_W'(cfg.pattern_length);

  // A result needs the output register; other bytes always advance.
  assign fire = head_valid && (!head.last || !out_valid_r || out_bus.ready);
  assign pop  = fire;

  assign out_bus.valid           = out_valid_r;
  assign out_bus.match_count     = out_count_r;
  assign out_bus.count_saturated = out_sat_r;

  always_comb begin
    fi    = field_index_r;
    bif   = byte_in_field_r;
    alive = prefix_alive_r;
    dec   = record_decided_r;
    mat   = record_matched_r;

    full_pre = !dec && (fi == cfg.target_field) && alive && (bif >= used_len);
    if (full_pre) begin
      dec = 1'b1;
      mat = 1'b1;
    end

    if (!dec) begin
      if (head.is_rs || head.is_fs) begin
        if (fi == cfg.target_field) begin
          dec = 1'b1;
        end else if (head.is_fs) begin
          if (fi != FIELD_INDEX_MAX) begin
            fi = fi + 1'b1;
          end
          bif   = '0;
          alive = 1'b1;
        end
      end else if (fi == cfg.target_field) begin
        if ((bif < used_len) && head.eq_vec[bif[IDX_W-1:0]]) begin
          bif = bif + 1'b1;
        end else begin
          alive = 1'b0;
          dec   = 1'b1;
        end
      end
    end

    full_post     = !dec && (fi == cfg.target_field) && alive && (bif >= used_len);
    close_now     = head.is_rs || head.last;
    close_matched = head.is_rs ? mat : (mat || full_post);

    count_nxt = count_r;
    sat_nxt   = sat_r;
    if (close_now && close_matched) begin
      if (count_r != '1) begin
        count_nxt = count_r + 1'b1;
      end
      if (count_nxt == '1) begin
        sat_nxt = 1'b1;
      end
    end

    if (close_now) begin
      field_index_nxt    = '0;
      byte_in_field_nxt  = '0;
      prefix_alive_nxt   = 1'b1;
      record_decided_nxt = 1'b0;
      record_matched_nxt = 1'b0;
    end else begin
      field_index_nxt    = fi;
      byte_in_field_nxt  = bif;
      prefix_alive_nxt   = alive;
      record_decided_nxt = dec;
      record_matched_nxt = mat;
    end

    out_valid_nxt = out_valid_r;
    if (fire && head.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r    <= '0;
      byte_in_field_r  <= '0;
      prefix_alive_r   <= 1'b1;
      record_decided_r <= 1'b0;
      record_matched_r <= 1'b0;
      count_r          <= '0;
      sat_r            <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        field_index_r    <= field_index_nxt;
        byte_in_field_r  <= byte_in_field_nxt;
        prefix_alive_r   <= prefix_alive_nxt;
        record_decided_r <= record_decided_nxt;
        record_matched_r <= record_matched_nxt;
        if (head.last) begin
          count_r <= '0;
          sat_r   <= 1'b0;
        end else begin
          count_r <= count_nxt;
          sat_r   <= sat_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && head.last) begin
      out_count_r <= RESULT_W'(count_nxt);
      out_sat_r   <= sat_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && head.last) |=> (count_r == '0 && !sat_r))
    else $error("count not cleared after result");

  a_sat_means_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (count_r == '1))
    else $error("saturation flag without full count");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_in_field_r <= POS_W'(MAX_PATTERN_BYTES))
    else $error("byte position past pattern size");

  a_matched_decided: assert property (@(posedge clk) disable iff (!rst_n)
    record_matched_r |-> record_decided_r)
    else $error("record matched but not decided");
`endif

endmodule

FILE: rtl/csv_field_prefix_match_counter_top.sv
// Top level of the CSV field prefix match counter.
// Holds the configuration registers and joins front, queue and back.
// Depends on csvf_pkg, csvf_in_if, csvf_out_if, csvf_front, csvf_fifo, csvf_back.
//
//   channel   direction  transaction / write
//   in_bus    sink       one text byte, end_of_buffer flags the last one
//   out_bus   source     match_count and count_saturated, once per buffer
//   cfg_*     write      register index and data, taken when cfg_we is high
//
// One byte per cycle sustained, except that a buffer's last byte stalls while the
// previous result still waits on out_bus. The record walk in the back updates the
// field index, byte position and flags on every byte taken from the queue; a result
// leaves through the queue and the result register after its last byte is taken.
// Reset (rst_n low, synchronous) clears all record state, the count and queue.
// A two-entry queue and the result register let input and output stall apart;
// in_bus.ready drops only while the queue is full.
module csv_field_prefix_match_counter_top
  import csvf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  csvf_in_if.sink                in_bus,
  csvf_out_if.source             out_bus,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t   cfg_r;
  logic   push, pop;
  logic   fifo_full, fifo_empty;
  entry_t push_entry, head_entry;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_field     <= '0;
      cfg_r.pattern_low      <= '0;
      cfg_r.pattern_high     <= '0;
      cfg_r.pattern_length   <= '0;
      cfg_r.field_separator  <= FS_RESET;
      cfg_r.record_separator <= RS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_FIELD:     cfg_r.target_field     <= cfg_wdata[FIELD_W-1:0];
        CFG_PATTERN_LOW:      cfg_r.pattern_low      <= cfg_wdata[PAT_WORD_W-1:0];
        CFG_PATTERN_HIGH:     cfg_r.pattern_high     <= cfg_wdata[PAT_WORD_W-1:0];
        CFG_PATTERN_LENGTH:   cfg_r.pattern_length   <= cfg_wdata[PLEN_W-1:0];
        CFG_FIELD_SEPARATOR:  cfg_r.field_separator  <= cfg_wdata[BYTE_W-1:0];
        CFG_RECORD_SEPARATOR: cfg_r.record_separator <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify each byte on the way in.
  csvf_front u_front (
    .in_bus    (in_bus),
    .cfg       (cfg_r),
    .fifo_full (fifo_full),
    .push      (push),
    .entry     (push_entry)
  );

  // Decouple classification from the record walk.
  csvf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_entry),
    .pop   (pop),
    .dout  (head_entry),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  // Walk records, count matches, hold the result until taken.
  csvf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (!fifo_empty),
    .head       (head_entry),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

FILE: dv/tb.sv
// Self-checking bench for csv_field_prefix_match_counter_top: drives text bytes,
// predicts one match count per buffer and compares every result transaction.
// Depends on csvf_pkg, csvf_in_if, csvf_out_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csvf_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_WAIT      = 8;
  localparam int SETTLE_CYCLES = 8;     // result leaves through the queue and the result register
  localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction before giving up
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_BYTES   = 110;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [RESULT_W-1:0]    COUNT_CEIL   = '1;
  localparam logic [BYTE_W-1:0]      ASCII_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0]      ASCII_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0]      ASCII_SEMI    = 8'h3B;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } text_byte_t;

  typedef struct {
    logic [RESULT_W-1:0] count;
    logic                saturated;
  } tally_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  csvf_in_if  in_bus ();
  csvf_out_if out_bus ();

  csv_field_prefix_match_counter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be offered, and counts still owed by the block.
  text_byte_t text_bytes[$];
  tally_t     pending_counts[$];

  // Shadow copy of the configuration registers.
  logic [FIELD_W-1:0]    m_target;
  logic [PAT_WORD_W-1:0] m_pat_lo;
  logic [PAT_WORD_W-1:0] m_pat_hi;
  logic [PLEN_W-1:0]     m_pat_len;
  logic [BYTE_W-1:0]     m_fs;
  logic [BYTE_W-1:0]     m_rs;

  // Record walk state of the predictor.
  logic [FIELD_W-1:0]  cur_field;
  logic [POS_W-1:0]    matched_len;
  logic                prefix_ok;
  logic                verdict_done;
  logic                verdict_hit;
  logic [RESULT_W-1:0] hit_count;
  logic                hit_saturated;

  int errors         = 0;
  int stalled_cycles = 0;
  int in_gap         = 0;
  int out_wait       = 0;
  bit out_drawn      = 0;
  bit in_fire        = 0;
  bit out_fire       = 0;
  bit steady_in      = 0;
  bit steady_out     = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: walk each accepted byte through the record/field state.
  // ---------------------------------------------------------------------------

  function automatic logic [POS_W-1:0] used_len();
    return (m_pat_len > MAX_PATTERN_BYTES) ? POS_W'(MAX_PATTERN_BYTES) : POS_W'(m_pat_len);
  endfunction

  // Bit 7 of the top byte of each pattern word is not stored and reads as 0.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [3:0] pos);
    logic [PAT_WORD_W-1:0] word;
    word = pos[3] ? m_pat_hi : m_pat_lo;
    return BYTE_W'({1'b0, word} >> (pos[2:0] * 8));
  endfunction

  task automatic start_record();
    cur_field    = '0;
    matched_len  = '0;
    prefix_ok    = 1'b1;
    verdict_done = 1'b0;
    verdict_hit  = 1'b0;
  endtask

  // Decide a match once the whole pattern has been seen in the target field.
  task automatic settle_prefix();
    if (!verdict_done && cur_field == m_target && prefix_ok && matched_len >= used_len()) begin
      verdict_done = 1'b1;
      verdict_hit  = 1'b1;
    end
  endtask

  task automatic close_record();
    if (verdict_hit) begin
      if (hit_count != COUNT_CEIL) hit_count++;
      if (hit_count == COUNT_CEIL) hit_saturated = 1'b1;
    end
    start_record();
  endtask

  task automatic reset_model();
    m_target      = '0;
    m_pat_lo      = '0;
    m_pat_hi      = '0;
    m_pat_len     = '0;
    m_fs          = FS_RESET;
    m_rs          = RS_RESET;
    hit_count     = '0;
    hit_saturated = 1'b0;
    start_record();
  endtask

  task automatic count_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic   is_rs;
    logic   is_fs;
    tally_t owed;
    // A byte equal to both separators ends the record.
    is_rs = (b == m_rs);
    is_fs = !is_rs && (b == m_fs);
    settle_prefix();
    if (!verdict_done) begin
      if (is_rs || is_fs) begin
        if (cur_field == m_target) begin
          verdict_done = 1'b1;
        end else if (is_fs) begin
          if (cur_field != FIELD_INDEX_MAX) cur_field++;
          matched_len = '0;
          prefix_ok   = 1'b1;
        end
      end else if (cur_field == m_target) begin
        if (matched_len < used_len() && pattern_byte(matched_len[3:0]) == b) begin
          matched_len++;
        end else begin
          prefix_ok    = 1'b0;
          verdict_done = 1'b1;
        end
      end
    end
    if (is_rs) begin
      close_record();
    end else if (last) begin
      // An unterminated final record still counts.
      settle_prefix();
      close_record();
    end
    if (last) begin
      owed.count     = hit_count;
      owed.saturated = hit_saturated;
      pending_counts.push_back(owed);
      hit_count     = '0;
      hit_saturated = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on accepted bytes, check results.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tally_t want;
    in_fire  = rst_n && in_bus.valid && in_bus.ready;
    out_fire = rst_n && out_bus.valid && out_bus.ready;
    if (in_fire) begin
      count_byte(in_bus.data_byte, in_bus.end_of_buffer);
      void'(text_bytes.pop_front());
    end
    if (out_fire) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("result with no buffer outstanding: count=%0d sat=%0b",
                                  out_bus.match_count, out_bus.count_saturated));
      end else begin
        want = pending_counts.pop_front();
        if (out_bus.match_count !== want.count)
          report_mismatch($sformatf("match_count %0d, predicted %0d",
                                    out_bus.match_count, want.count));
        if (out_bus.count_saturated !== want.saturated)
          report_mismatch($sformatf("count_saturated %0b, predicted %0b",
                                    out_bus.count_saturated, want.saturated));
      end
    end
    stalled_cycles = (in_fire || out_fire) ? 0 : stalled_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: hold the offered byte until taken, then wait the drawn gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (text_bytes.size() > 0) begin
        in_bus.valid         <= 1'b1;
        in_bus.data_byte     <= text_bytes[0].data;
        in_bus.end_of_buffer <= text_bytes[0].last;
        in_gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall each waiting result for a drawn number of cycles,
  // toggle ready at random while nothing waits.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (out_bus.valid && !out_fire) begin
      if (!out_drawn) begin
        out_wait  = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
        out_drawn = 1'b1;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end else begin
      out_drawn = 1'b0;
      out_bus.ready <= steady_out || ($urandom_range(0, 1) == 1);
    end
  end

  // Abort when the handshakes have gone quiet for too long.
  initial begin : watchdog
    while (stalled_cycles < IDLE_LIMIT) @(negedge clk);
    $display("csv_field_prefix_match_counter_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Registers change only while the block is idle, so the shadow copy
  // can be updated right after the write edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET_FIELD:     m_target  = val[FIELD_W-1:0];
      CFG_PATTERN_LOW:      m_pat_lo  = val;
      CFG_PATTERN_HIGH:     m_pat_hi  = val;
      CFG_PATTERN_LENGTH:   m_pat_len = val[PLEN_W-1:0];
      CFG_FIELD_SEPARATOR:  m_fs      = val[BYTE_W-1:0];
      CFG_RECORD_SEPARATOR: m_rs      = val[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; narrow ones get random upper bits that must be dropped.
  // Finish with a write to an unused index, which must change nothing.
  task automatic load_setup(input logic [FIELD_W-1:0] tgt, input logic [PAT_WORD_W-1:0] lo,
                            input logic [PAT_WORD_W-1:0] hi, input logic [PLEN_W-1:0] len,
                            input logic [BYTE_W-1:0] fs, input logic [BYTE_W-1:0] rs);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    junk[FIELD_W-1:0] = tgt;
    write_reg(CFG_TARGET_FIELD, junk);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    junk = CFG_DATA_W'({$urandom, $urandom});
    junk[PLEN_W-1:0] = len;
    write_reg(CFG_PATTERN_LENGTH, junk);
    junk = CFG_DATA_W'({$urandom, $urandom});
    junk[BYTE_W-1:0] = fs;
    write_reg(CFG_FIELD_SEPARATOR, junk);
    junk = CFG_DATA_W'({$urandom, $urandom});
    junk[BYTE_W-1:0] = rs;
    write_reg(CFG_RECORD_SEPARATOR, junk);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
              CFG_DATA_W'({$urandom, $urandom}));
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    text_byte_t item;
    item.data = b;
    item.last = last;
    text_bytes.push_back(item);
  endtask

  task automatic push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == m_fs || b == m_rs);
    return b;
  endfunction

  // Build one well-formed buffer of 1 to 4 records with random content, a
  // sprinkle of raw noise bytes, and sometimes no terminator on the last record.
  // Assemble it locally so the end-of-buffer flag is known before queuing.
  task automatic queue_buffer(output int n_bytes);
    logic [BYTE_W-1:0] chunk[$];
    int n_records;
    int n_fields;
    int fill;
    int mode;
    int cut;
    int ulen;
    ulen       = int'(used_len());
    n_records  = $urandom_range(1, 4);
    steady_in  = ($urandom_range(0, 4) == 0);
    steady_out = ($urandom_range(0, 4) == 0);
    for (int r = 0; r < n_records; r++) begin
      n_fields = $urandom_range(1, int'(m_target) + 3);
      for (int f = 0; f < n_fields; f++) begin
        if (f > 0) chunk.push_back(m_fs);
        if ($urandom_range(0, 24) == 0) chunk.push_back(BYTE_W'($urandom));
        if (f == m_target) begin
          mode = $urandom_range(0, 7);
          cut  = (ulen > 0) ? $urandom_range(0, ulen - 1) : 0;
          fill = 0;
          if (mode < 4) begin
            // full pattern, possibly followed by more text
            for (int k = 0; k < ulen; k++) chunk.push_back(pattern_byte(4'(k)));
            fill = $urandom_range(0, 2);
          end else if (mode == 4) begin
            // field cut short inside the pattern
            for (int k = 0; k < cut; k++) chunk.push_back(pattern_byte(4'(k)));
          end else if (mode == 5) begin
            // one pattern byte replaced
            for (int k = 0; k < ulen; k++)
              chunk.push_back((k == cut) ? plain_byte() : pattern_byte(4'(k)));
            fill = $urandom_range(0, 2);
          end else begin
            fill = $urandom_range(0, 3);
          end
        end else begin
          fill = (m_target > 8) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        end
        repeat (fill) chunk.push_back(plain_byte());
      end
      if (r < n_records - 1 || chunk.size() == 0 || $urandom_range(0, 1) == 1)
        chunk.push_back(m_rs);
    end
    foreach (chunk[i]) push_byte(chunk[i], i == chunk.size() - 1);
    n_bytes = chunk.size();
  endtask

  // Hold until every byte is taken and every count has come back, then let
  // the pipeline settle.
  task automatic wait_idle();
    while (text_bytes.size() != 0 || in_bus.valid || pending_counts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                    made;
    int                    budget;
    logic [FIELD_W-1:0]    tgt;
    logic [PAT_WORD_W-1:0] lo;
    logic [PAT_WORD_W-1:0] hi;
    logic [PLEN_W-1:0]     len;
    logic [BYTE_W-1:0]     fs;
    logic [BYTE_W-1:0]     rs;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.end_of_buffer = 1'b0;
    out_bus.ready        = 1'b0;
    reset_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, empty pattern: every record holding field 0 matches,
    // even an empty one; an unterminated last record counts. Extreme bytes.
    write_reg(CFG_SPARE_HI, '1);
    push_text(",\n", 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // Field 1 against "US": a hit, a record missing the field, and a final
    // unterminated field shorter than the pattern.
    load_setup(6'd1, 63'h5355, '0, 5'd2, ASCII_COMMA, ASCII_NEWLINE);
    push_text("a,USx\nb\nc,U", 1'b1);
    wait_idle();

    // Both separators the same byte: it must act as a record end.
    load_setup(6'd0, 63'h41, '0, 5'd1, ASCII_SEMI, ASCII_SEMI);
    push_text("A;B;A", 1'b1);
    wait_idle();

    // Random phases: each one a fresh setting, drained before the next.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tgt = FIELD_W'($urandom_range(0, 4));
      lo  = PAT_WORD_W'({$urandom, $urandom});
      hi  = PAT_WORD_W'({$urandom, $urandom});
      len = PLEN_W'($urandom_range(0, 6));
      fs  = ASCII_COMMA;
      rs  = ASCII_NEWLINE;
      if ($urandom_range(0, 2) == 0) begin
        fs = BYTE_W'($urandom);
        rs = BYTE_W'($urandom);
      end
      case (p)
        0: len = 5'd16;
        1: begin
          // last field index; records long enough to pin the field counter
          tgt = FIELD_INDEX_MAX;
          len = 5'd2;
        end
        2: begin
          // all-ones pattern with separator bytes at the extremes
          lo  = '1;
          hi  = '1;
          len = '1;
          fs  = 8'h00;
          rs  = 8'hFF;
        end
        3: begin
          len = '0;
          rs  = fs;
        end
        4: begin
          // pattern containing the field separator never matches
          lo[BYTE_W-1:0] = fs;
          len = 5'd3;
        end
        5: len = PLEN_W'($urandom_range(MAX_PATTERN_BYTES + 1, 31));
        default: len = PLEN_W'($urandom_range(0, MAX_PATTERN_BYTES));
      endcase
      load_setup(tgt, lo, hi, len, fs, rs);
      budget = 0;
      while (budget < PHASE_BYTES) begin
        queue_buffer(made);
        budget += made;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("csv_field_prefix_match_counter_top verification clean");
    end else begin
      $display("csv_field_prefix_match_counter_top verification failed");
    end
    $finish;
  end

endmodule
